// ----- src/rsb_pkg.sv -----
// Shared types and constants for the retransmit send buffer.
package rsb_pkg;

  localparam int DEPTH_DEFAULT       = 32;
  localparam int HANDLE_BITS_DEFAULT = 16;

  localparam int SEQ_BITS    = 31;
  localparam int TIME_BITS   = 32;
  localparam int CAP_BITS    = 6;
  localparam int HELD_BITS   = 6;
  localparam int OP_BITS     = 2;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [TIME_BITS-1:0] HALF_RANGE    = 32'h0000_0001 << 31;
  localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = 32'hffff_ffff;

  localparam logic [CAP_BITS-1:0]  CAPACITY_RESET = 6'd32;
  localparam logic [TIME_BITS-1:0] LATENCY_RESET  = 32'd120000;

  localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ACK    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_LATENCY  = 2'd1;
  localparam logic [1:0] REG_TLD_EN   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_DROP_RD,
    S_DROP_SPAN,
    S_DROP_CMP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT,
    S_STATUS
  } state_t;

endpackage

// ----- src/rsb_in_if.sv -----
// Input channel: push, acknowledge and lookup items.
interface rsb_in_if
  import rsb_pkg::*;
#(
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     operation;
  logic [SEQ_BITS-1:0]    seq_number;
  logic [TIME_BITS-1:0]   packet_timestamp;
  logic [HANDLE_BITS-1:0] packet_handle;
  logic [SEQ_BITS-1:0]    range_end;

  modport source (output valid, operation, seq_number, packet_timestamp, packet_handle,
                  range_end, input ready);
  modport sink (input valid, operation, seq_number, packet_timestamp, packet_handle,
                range_end, output ready);
endinterface

// ----- src/rsb_out_if.sv -----
// Output channel: status and retransmit entry items.
interface rsb_out_if
  import rsb_pkg::*;
#(
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic                   entry_valid;
  logic [HANDLE_BITS-1:0] found_handle;
  logic [SEQ_BITS-1:0]    found_seq;
  logic                   last_of_run;
  logic [HELD_BITS-1:0]   held_count;

  modport source (output valid, entry_valid, found_handle, found_seq, last_of_run,
                  held_count, input ready);
  modport sink (input valid, entry_valid, found_handle, found_seq, last_of_run,
                held_count, output ready);
endinterface

// ----- src/retransmit_send_buffer_core.sv -----
// Retransmit send buffer: packet ring in one memory, scanned by a sequencer.
//
// Items are handled one at a time. All entries live in a single memory with one
// write port and one read port whose data is registered, so every entry visit is an
// address step, then a data step; an emitted entry adds a step to load the output
// register. A push writes the new entry; when too-late drop is on and two or more
// packets remain, it then reads the oldest entry, takes the timestamp span to the new
// packet and drops the oldest while that span exceeds the latency limit. An acknowledge
// or a lookup scans from the oldest entry; a lookup that finds its start emits each
// entry from it through its end sequence or the newest. The next item is taken in the
// cycle after the one that loads the last result item. A waiting output item does
// not block the next input from being taken; the sequencer stalls only when it must
// emit into a full output register. No clearing pass follows reset.
module retransmit_send_buffer_core
  import rsb_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEFAULT,
  parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  rsb_in_if.sink               cmd,
  rsb_out_if.source            res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = CW + 1;
  localparam int CAPW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int EW   = SEQ_BITS + TIME_BITS + HANDLE_BITS;

  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[IW-1:0];
  endfunction

  // configuration
  logic [CAP_BITS-1:0]  queue_capacity;
  logic [TIME_BITS-1:0] latency_limit;
  logic                 tld_enable;
  logic                 cfg_write;
  logic [CW-1:0]        cap_eff;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_capacity <= CAPACITY_RESET;
      latency_limit  <= LATENCY_RESET;
      tld_enable     <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_CAPACITY: queue_capacity <= pwdata[CAP_BITS-1:0];
        REG_LATENCY:  latency_limit  <= pwdata[TIME_BITS-1:0];
        REG_TLD_EN:   tld_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CAPACITY: prdata = DATA_BITS'(queue_capacity);
      REG_LATENCY:  prdata = DATA_BITS'(latency_limit);
      REG_TLD_EN:   prdata = DATA_BITS'(tld_enable);
      default:      prdata = '0;
    endcase
  end

  assign cap_eff = (CAPW'(queue_capacity) > CAPW'(DEPTH)) ? CW'(DEPTH)
                                                         : CW'(queue_capacity);

  // entry memory
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [SEQ_BITS-1:0]    rd_seq;
  logic [TIME_BITS-1:0]   rd_tstamp;
  logic [HANDLE_BITS-1:0] rd_handle;

  // A push writes only the newest slot; drop reads start at the oldest slot with
  // at least two entries held, so a read never follows a write to the same entry.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign rd_seq    = rd_data[EW-1 -: SEQ_BITS];
  assign rd_tstamp = rd_data[HANDLE_BITS +: TIME_BITS];
  assign rd_handle = rd_data[HANDLE_BITS-1:0];

  // sequencer state
  state_t               state, state_next;
  logic [CW-1:0]        entry_count, entry_count_next;
  logic [IW-1:0]        oldest_index, oldest_index_next;
  logic [CW-1:0]        pos, pos_next;
  logic                 found, found_next;
  logic [TIME_BITS-1:0] span, span_next;

  logic [OP_BITS-1:0]     op_q;
  logic [SEQ_BITS-1:0]    seq_q;
  logic [TIME_BITS-1:0]   ts_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SEQ_BITS-1:0]    end_q;
  logic                   cmd_fire;

  // output register
  logic                   out_valid;
  logic                   out_entry;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [SEQ_BITS-1:0]    out_seq;
  logic                   out_last;
  logic [HELD_BITS-1:0]   out_count;
  logic                   out_free;
  logic                   out_load;
  logic                   out_entry_next;
  logic [HANDLE_BITS-1:0] out_handle_next;
  logic [SEQ_BITS-1:0]    out_seq_next;
  logic                   out_last_next;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  // push arithmetic
  logic                 full;
  logic [IW-1:0]        o1;
  logic [CW-1:0]        c1, c2;
  logic [TIME_BITS-1:0] dur;
  logic                 emit_last;

  always_comb begin
    state_next        = state;
    entry_count_next  = entry_count;
    oldest_index_next = oldest_index;
    pos_next          = pos;
    found_next        = found;
    span_next         = span;
    rd_en             = 1'b0;
    rd_addr           = ring_slot(oldest_index, pos);
    wr_en             = 1'b0;
    full              = (entry_count == CW'(DEPTH));
    o1                = full ? ring_slot(oldest_index, CW'(1)) : oldest_index;
    c1                = full ? CW'(DEPTH - 1) : entry_count;
    c2                = c1 + CW'(1);
    wr_addr           = ring_slot(o1, c1);
    wr_data           = {seq_q, ts_q, handle_q};
    dur               = (ts_q > rd_tstamp) ? ts_q - rd_tstamp : rd_tstamp - ts_q;
    emit_last         = (rd_seq == end_q) || (pos + CW'(1) == entry_count);
    out_load          = 1'b0;
    out_entry_next    = 1'b0;
    out_handle_next   = '0;
    out_seq_next      = '0;
    out_last_next     = 1'b1;

    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          pos_next   = '0;
          found_next = 1'b0;
          case (cmd.operation)
            OP_PUSH: state_next = S_PUSH;
            OP_ACK, OP_LOOKUP: state_next = (entry_count == '0) ? S_STATUS : S_SCAN_RD;
            default: state_next = S_STATUS;
          endcase
        end
      end
      S_PUSH: begin
        wr_en = 1'b1;
        if (c2 > cap_eff) begin
          oldest_index_next = ring_slot(o1, c2 - cap_eff);
          entry_count_next  = cap_eff;
        end else begin
          oldest_index_next = o1;
          entry_count_next  = c2;
        end
        state_next = (tld_enable && entry_count_next >= CW'(2)) ? S_DROP_RD : S_STATUS;
      end
      S_DROP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = oldest_index;
        state_next = S_DROP_SPAN;
      end
      S_DROP_SPAN: begin
        // fold spans past half the range back as a wrap
        span_next  = (dur > HALF_RANGE) ? TIME_ALL_ONES - dur : dur;
        state_next = S_DROP_CMP;
      end
      S_DROP_CMP: begin
        if (span > latency_limit) begin
          oldest_index_next = ring_slot(oldest_index, CW'(1));
          entry_count_next  = entry_count - CW'(1);
          state_next        = (entry_count >= CW'(3)) ? S_DROP_RD : S_STATUS;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_SCAN_RD: begin
        rd_en      = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (found) begin
          state_next = S_EMIT;
        end else if (rd_seq == seq_q) begin
          if (op_q == OP_ACK) begin
            oldest_index_next = ring_slot(oldest_index, pos);
            entry_count_next  = entry_count - pos;
            state_next        = S_STATUS;
          end else begin
            found_next = 1'b1;
            state_next = S_EMIT;
          end
        end else if (pos + CW'(1) == entry_count) begin
          state_next = S_STATUS;
        end else begin
          pos_next   = pos + CW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_entry_next  = 1'b1;
          out_handle_next = rd_handle;
          out_seq_next    = rd_seq;
          out_last_next   = emit_last;
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            pos_next   = pos + CW'(1);
            state_next = S_SCAN_RD;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      oldest_index <= '0;
      pos          <= '0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      entry_count  <= entry_count_next;
      oldest_index <= oldest_index_next;
      pos          <= pos_next;
      found        <= found_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    span <= span_next;
    if (cmd_fire) begin
      op_q     <= cmd.operation;
      seq_q    <= cmd.seq_number;
      ts_q     <= cmd.packet_timestamp;
      handle_q <= cmd.packet_handle;
      end_q    <= cmd.range_end;
    end
    if (out_load) begin
      out_entry  <= out_entry_next;
      out_handle <= out_handle_next;
      out_seq    <= out_seq_next;
      out_last   <= out_last_next;
      out_count  <= HELD_BITS'(entry_count_next);
    end
  end

  assign res.valid        = out_valid;
  assign res.entry_valid  = out_entry;
  assign res.found_handle = out_handle;
  assign res.found_seq    = out_seq;
  assign res.last_of_run  = out_last;
  assign res.held_count   = out_count;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count exceeds ring depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, oldest_index} < (IW + 1)'(DEPTH))
    else $error("oldest index outside ring");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (state != S_IDLE))
    else $error("sequencer idle right after taking an item");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.entry_valid) |-> res.last_of_run)
    else $error("status item not marked last");
`endif

endmodule

// ----- dv/retransmit_send_buffer_core_tb.sv -----
// Testbench for the retransmit send buffer core: predicted ring behavior checked per result item.
module retransmit_send_buffer_core_tb
  import rsb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int HB    = HANDLE_BITS_DEFAULT;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 50;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    bit [OP_BITS-1:0]   op;
    bit [SEQ_BITS-1:0]  seq;
    bit [TIME_BITS-1:0] stamp;
    bit [HB-1:0]        handle;
    bit [SEQ_BITS-1:0]  last_seq;
  } cmd_t;

  typedef struct {
    bit                 has_entry;
    bit [HB-1:0]        handle;
    bit [SEQ_BITS-1:0]  seq;
    bit                 fin;
    bit [HELD_BITS-1:0] held;
  } resp_t;

  // Ring predictor plus the queue of result items still owed by the block.
  class send_buffer_scoreboard;
    bit [SEQ_BITS-1:0]  ring_seq[DEPTH];
    bit [TIME_BITS-1:0] ring_stamp[DEPTH];
    bit [HB-1:0]        ring_handle[DEPTH];
    int unsigned        head;
    int unsigned        held;
    bit [CAP_BITS-1:0]  capacity = CAPACITY_RESET;
    bit [TIME_BITS-1:0] latency  = LATENCY_RESET;
    bit                 late_drop;
    resp_t              pending[$];
    int                 errors;
    int                 checked;
    int                 entries;

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function int unsigned slot(int unsigned pos);
      return (head + pos) % DEPTH;
    endfunction

    function bit [SEQ_BITS-1:0] seq_at(int unsigned pos);
      return ring_seq[slot(pos)];
    endfunction

    function void drop_oldest();
      if (held == 0) return;
      head = (head + 1) % DEPTH;
      held--;
    endfunction

    // Timestamp distance between oldest and newest, folded past half range.
    function bit [TIME_BITS-1:0] span();
      bit [TIME_BITS-1:0] first, newest, dur;
      if (held == 0) return '0;
      first  = ring_stamp[slot(0)];
      newest = ring_stamp[slot(held - 1)];
      dur = (newest > first) ? newest - first : first - newest;
      if (dur > HALF_RANGE) dur = TIME_ALL_ONES - dur;
      return dur;
    endfunction

    function int unsigned locate(bit [SEQ_BITS-1:0] s);
      int unsigned p;
      for (p = 0; p < held; p++)
        if (ring_seq[slot(p)] == s) break;
      return p;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DATA_BITS-1:0] val);
      case (idx)
        REG_CAPACITY: capacity = val[CAP_BITS-1:0];
        REG_LATENCY:  latency  = val[TIME_BITS-1:0];
        REG_TLD_EN:   late_drop = val[0];
        default: ;
      endcase
    endfunction

    function void queue_result(bit has_entry, bit [HB-1:0] h, bit [SEQ_BITS-1:0] s, bit fin);
      resp_t r;
      r.has_entry = has_entry;
      r.handle    = h;
      r.seq       = s;
      r.fin       = fin;
      r.held      = held[HELD_BITS-1:0];
      pending = {pending, r};
    endfunction

    function void note_input(cmd_t c);
      int unsigned cap, p, s;
      bit fin;
      case (c.op)
        OP_PUSH: begin
          cap = (capacity > DEPTH) ? DEPTH : capacity;
          if (held >= DEPTH) drop_oldest();
          s = slot(held);
          ring_seq[s]    = c.seq;
          ring_stamp[s]  = c.stamp;
          ring_handle[s] = c.handle;
          held++;
          while (held > cap) drop_oldest();
          while (late_drop && span() > latency) drop_oldest();
          queue_result(1'b0, '0, '0, 1'b1);
        end
        OP_ACK: begin
          p = locate(c.seq);
          if (p < held) begin
            head = slot(p);
            held -= p;
          end
          queue_result(1'b0, '0, '0, 1'b1);
        end
        OP_LOOKUP: begin
          p = locate(c.seq);
          if (p >= held) begin
            queue_result(1'b0, '0, '0, 1'b1);
          end else if (c.seq == c.last_seq) begin
            s = slot(p);
            queue_result(1'b1, ring_handle[s], ring_seq[s], 1'b1);
          end else begin
            // emit through the end sequence, or through the newest if it never shows up
            for (int unsigned q = p; q < held; q++) begin
              s = slot(q);
              fin = (ring_seq[s] == c.last_seq) || (q == held - 1);
              queue_result(1'b1, ring_handle[s], ring_seq[s], fin);
              if (fin) break;
            end
          end
        end
        default: begin
          queue_result(1'b0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    task check_result(resp_t got);
      resp_t want;
      checked++;
      if (got.has_entry) entries++;
      if (pending.size() == 0) begin
        report($sformatf("result item with nothing pending (seq %0h, handle %0h)",
                         got.seq, got.handle));
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.has_entry != want.has_entry)
        report($sformatf("entry_valid %0b, want %0b", got.has_entry, want.has_entry));
      if (got.handle != want.handle)
        report($sformatf("found_handle %0h, want %0h", got.handle, want.handle));
      if (got.seq != want.seq)
        report($sformatf("found_seq %0h, want %0h", got.seq, want.seq));
      if (got.fin != want.fin)
        report($sformatf("last_of_run %0b, want %0b", got.fin, want.fin));
      if (got.held != want.held)
        report($sformatf("held_count %0d, want %0d", got.held, want.held));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic                 pready;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;

  rsb_in_if  #(.HANDLE_BITS(HB)) cmd_if ();
  rsb_out_if #(.HANDLE_BITS(HB)) res_if ();

  retransmit_send_buffer_core #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HB)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if.sink),
    .res     (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  send_buffer_scoreboard sb = new();

  bit                 no_idle;
  bit [SEQ_BITS-1:0]  next_seq;
  bit [TIME_BITS-1:0] next_ts;
  bit [TIME_BITS-1:0] ts_step;
  int                 ack_weight;
  int                 sent;
  int                 cfg_writes;
  int                 phases;
  int                 stuck_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid            <= 1'b1;
    cmd_if.operation        <= c.op;
    cmd_if.seq_number       <= c.seq;
    cmd_if.packet_timestamp <= c.stamp;
    cmd_if.packet_handle    <= c.handle;
    cmd_if.range_end        <= c.last_seq;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_input(c);
    sent++;
  endtask

  task automatic issue(bit [OP_BITS-1:0] op, bit [SEQ_BITS-1:0] s, bit [TIME_BITS-1:0] t,
                       bit [HB-1:0] h, bit [SEQ_BITS-1:0] e);
    cmd_t c;
    c.op       = op;
    c.seq      = s;
    c.stamp    = t;
    c.handle   = h;
    c.last_seq = e;
    send_cmd(c);
  endtask

  // psel stays high between back-to-back writes; the caller lowers it
  task automatic reg_write(logic [1:0] idx, logic [DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic configure(bit [CAP_BITS-1:0] cap, bit [TIME_BITS-1:0] lat, bit en);
    cmd_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(REG_CAPACITY, DATA_BITS'(cap));
    reg_write(REG_LATENCY, lat);
    reg_write(REG_TLD_EN, DATA_BITS'(en));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly in-order pushes with acks and lookups aimed at held entries; rest is noise.
  function automatic void make_random(output cmd_t c);
    int unsigned pick, p;
    c.op       = OP_PUSH;
    c.seq      = SEQ_BITS'($urandom());
    c.stamp    = $urandom();
    c.handle   = HB'($urandom());
    c.last_seq = SEQ_BITS'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 60 - ack_weight) begin
      c.seq = next_seq;
      next_seq++;
      if (ts_step != TIME_ALL_ONES) c.stamp = next_ts + $urandom_range(0, ts_step);
      next_ts = c.stamp;
    end else if (pick < 60) begin
      c.op = OP_ACK;
      if (sb.held > 0) c.seq = sb.seq_at($urandom_range(0, sb.held - 1));
    end else if (pick < 80) begin
      c.op = OP_LOOKUP;
      if (sb.held > 0) begin
        p = $urandom_range(0, sb.held - 1);
        c.seq = sb.seq_at(p);
        case ($urandom_range(0, 3))
          0: c.last_seq = c.seq;
          1: c.last_seq = sb.seq_at($urandom_range(p, sb.held - 1));
          2: c.last_seq = sb.seq_at($urandom_range(0, p));
          default: ;
        endcase
      end
    end else if (pick < 86) begin
      // duplicate sequence: acks and lookups must hit the first copy
      if (sb.held > 0) c.seq = sb.seq_at($urandom_range(0, sb.held - 1));
      c.stamp = next_ts;
    end else if (pick < 91) begin
      c.op = OP_UNUSED;
    end else begin
      c.op = OP_BITS'($urandom_range(0, 2));
    end
  endfunction

  task automatic run_phase(bit [CAP_BITS-1:0] cap, bit [TIME_BITS-1:0] lat, bit en,
                           bit [TIME_BITS-1:0] ts_base, bit [TIME_BITS-1:0] step, int ack_w);
    cmd_t c;
    configure(cap, lat, en);
    next_seq   = SEQ_BITS'($urandom());
    next_ts    = ts_base;
    ts_step    = step;
    ack_weight = ack_w;
    phases++;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      no_idle = (i < 10);
      make_random(c);
      send_cmd(c);
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    cmd_if.valid            <= 1'b0;
    cmd_if.operation        <= OP_PUSH;
    cmd_if.seq_number       <= '0;
    cmd_if.packet_timestamp <= '0;
    cmd_if.packet_handle    <= '0;
    cmd_if.range_end        <= '0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty ring, unknown operation, field extremes
    issue(OP_LOOKUP, '0, '0, '0, '0);
    issue(OP_ACK, '1, '0, '0, '0);
    issue(OP_UNUSED, '1, '1, '1, '1);
    issue(OP_PUSH, '0, '0, '0, '1);
    issue(OP_PUSH, '1, '1, '1, '0);
    issue(OP_PUSH, 31'd5, 32'd100, 16'h1234, '0);
    issue(OP_PUSH, 31'd6, 32'd200, 16'habcd, '0);
    issue(OP_PUSH, 31'd7, 32'd300, 16'h5a5a, '0);
    // lookups: single entry, normal range, end missing, start missing, end earlier
    issue(OP_LOOKUP, '0, '0, '0, '0);
    issue(OP_LOOKUP, '1, '0, '0, 31'd6);
    issue(OP_LOOKUP, 31'd5, '0, '0, 31'd999);
    issue(OP_LOOKUP, 31'd42, '0, '0, 31'd6);
    issue(OP_LOOKUP, 31'd6, '0, '0, 31'd5);
    // acks: missing, then trimming the front
    issue(OP_ACK, 31'd12345, '0, '0, '0);
    issue(OP_ACK, 31'd5, '0, '0, '0);
    issue(OP_PUSH, 31'd5, 32'd400, 16'h00ff, '0);
    issue(OP_LOOKUP, 31'd5, '0, '0, 31'd5);
    issue(OP_ACK, '1, '0, '0, '0);
    issue(OP_UNUSED, '0, '0, '0, '0);
    issue(OP_ACK, 31'd7, '0, '0, '0);

    run_phase(6'd32, 32'd120000, 1'b0, $urandom(), 32'd1000, 2);
    run_phase(6'd63, TIME_ALL_ONES, 1'b0, $urandom(), 32'd500, 3);
    run_phase(6'd5, 32'd3000, 1'b1, 32'hffff_f000, 32'd1000, 10);
    run_phase(6'd0, 32'd0, 1'b0, $urandom(), 32'd100, 10);
    run_phase(6'd1, 32'd50, 1'b1, $urandom(), 32'd100, 10);
    run_phase(6'd32, 32'd0, 1'b1, $urandom(), 32'd2, 5);
    run_phase(6'd20, TIME_ALL_ONES, 1'b1, $urandom(), TIME_ALL_ONES, 8);
    run_phase(6'd16, 32'h7fff_ffff, 1'b1, $urandom(), TIME_ALL_ONES, 8);
    run_phase(CAP_BITS'($urandom_range(1, 40)), $urandom_range(0, 200000), 1'($urandom()),
              $urandom(), $urandom_range(1, 20000), 12);

    cmd_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d command items over %0d register settings (%0d register writes).",
             sent, phases + 1, cfg_writes);
    $display("Checked %0d result items, %0d of them retransmit entries, %0d mismatches.",
             sb.checked, sb.entries, sb.errors);
    if (sb.errors == 0) begin
      $display("retransmit_send_buffer_core verification clean");
    end else begin
      $display("retransmit_send_buffer_core verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    resp_t       got;
    int unsigned stall;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got.has_entry = res_if.entry_valid;
      got.handle    = res_if.found_handle;
      got.seq       = res_if.found_seq;
      got.fin       = res_if.last_of_run;
      got.held      = res_if.held_count;
      sb.check_result(got);
    end
  end

  // End the run if no handshake of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d result items outstanding.",
               stuck_cycles, sb.pending.size());
      $display("retransmit_send_buffer_core verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
src/rsb_pkg.sv
src/rsb_in_if.sv
src/rsb_out_if.sv
src/retransmit_send_buffer_core.sv
dv/retransmit_send_buffer_core_tb.sv
